@@ hw/rtl/assert_macros.svh @@
// Assertion helper macros used by the packet scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/wf2q_pkg.sv @@
// ----------------------------------------------------------------------------
// WF2Q scheduler package
// Shared types, sizes and status codes of the WF2Q packet scheduler.
// ----------------------------------------------------------------------------
package wf2q_pkg;
  localparam int unsigned NumFlows = 16;
  localparam int unsigned QueueDepth = 64;
  localparam int unsigned FlowW = $clog2(NumFlows);
  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned StoreDepth = NumFlows * QueueDepth;
  localparam int unsigned StoreAw = $clog2(StoreDepth);
  localparam int unsigned TagW = 64;
  localparam int unsigned WsumW = 16 + FlowW;
  localparam int unsigned EntryW = 46;
  localparam int unsigned StateW = 2 * TagW + 16 + 1 + CntW + 20 + 2 * PtrW;

  typedef logic [1:0] status_t;
  localparam status_t StEnq = 2'd0;
  localparam status_t StDrop = 2'd1;
  localparam status_t StDeq = 2'd2;
  localparam status_t StNone = 2'd3;

  localparam logic [1:0] CfgLimitByBytes = 2'd0;
  localparam logic [1:0] CfgMaxPackets = 2'd1;
  localparam logic [1:0] CfgMaxBytes = 2'd2;

  typedef struct packed {
    logic        func;
    logic [3:0]  flow_id;
    logic [13:0] pkt_length;
    logic [15:0] pkt_weight;
    logic [15:0] pkt_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  out_flow;
    logic [15:0] out_handle;
    logic [13:0] out_length;
  } out_item_t;

  typedef struct packed {
    logic [TagW-1:0] start_tag;
    logic [TagW-1:0] finish_tag;
    logic [15:0]     weight;
    logic            seen;
    logic [CntW-1:0] pkt_cnt;
    logic [19:0]     byte_cnt;
    logic [PtrW-1:0] head;
    logic [PtrW-1:0] tail;
  } flow_state_t;

  typedef struct packed {
    logic [13:0] len;
    logic [15:0] weight;
    logic [15:0] handle;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [13:0] len;
    logic [WsumW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [TagW-1:0] quo;
  } div_rsp_t;

  function automatic logic [TagW-1:0] sat_add(input logic [TagW-1:0] a,
                                              input logic [TagW-1:0] b);
    logic [TagW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TagW] ? '1 : s[TagW-1:0];
  endfunction

  function automatic logic [TagW-1:0] max_tag(input logic [TagW-1:0] a,
                                              input logic [TagW-1:0] b);
    return (a > b) ? a : b;
  endfunction
endpackage

@@ hw/rtl/wf2q_ram.sv @@
// ----------------------------------------------------------------------------
// WF2Q generic RAM
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module wf2q_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hw/rtl/wf2q_div.sv @@
// ----------------------------------------------------------------------------
// WF2Q service divider
// Restoring divider giving floor(len * 8 * 2^16 / divisor), one bit a cycle.
// ----------------------------------------------------------------------------
module wf2q_div
  import wf2q_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  localparam int unsigned NumW = 14 + 3 + 16;
  localparam int unsigned BitCntW = $clog2(NumW + 1);

  logic [NumW-1:0]    num_q, num_d;
  logic [WsumW-1:0]   den_q, den_d;
  logic [WsumW:0]     rem_q, rem_d;
  logic [NumW-1:0]    quo_q, quo_d;
  logic [BitCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               zero_q, zero_d;
  logic               done_q, done_d;
  logic [WsumW+1:0]   trial;

  always_comb begin
    num_d = num_q;
    den_d = den_q;
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    zero_d = zero_q;
    done_d = 1'b0;
    trial = '0;
    if (req_i.start) begin
      num_d = {req_i.len, 19'd0};
      den_d = req_i.divisor;
      zero_d = (req_i.divisor == '0);
      rem_d = '0;
      quo_d = '0;
      cnt_d = BitCntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, num_q[NumW-1]} - {2'b00, den_q};
      if (!trial[WsumW+1]) begin
        rem_d = trial[WsumW:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[WsumW-1:0], num_q[NumW-1]};
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      num_d = {num_q[NumW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == BitCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    zero_q <= zero_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo = zero_q ? '1 : {{(TagW-NumW){1'b0}}, quo_q};
endmodule

@@ hw/rtl/wf2q_packet_scheduler.sv @@
// A dequeue scans the flows, reads the served flow's head entry, divides for its new tags,
// rescans for the least start tag and divides to advance virtual time; the tag division is
// skipped when the flow empties, and nothing eligible ends after the first scan. A stamping
// enqueue also divides and scans the other flows. One transaction at a time, the next taken
// in the cycle after the result leaves; the flow scans and the bit-serial divider set the pace.
// Reset clears all flow state, taking no transaction; configuration resets.
// ----------------------------------------------------------------------------
// WF2Q packet scheduler
// Per-flow FIFOs with start and finish tags; serves the eligible flow with the least
// finish tag and advances virtual time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module wf2q_packet_scheduler
  import wf2q_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [19:0] cfg_data_i
);
  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ERD, S_EDEC, S_EDIV1, S_EWAIT1, S_ECHK2, S_EWAIT2, S_EPUSH,
    S_SCAN, S_SCANL, S_DPICK, S_DHEAD, S_DNEXT, S_DNEXTW, S_DDIV, S_DWAIT, S_DWB,
    S_MSCAN, S_MSCANL, S_VDIV, S_VWAIT, S_OUT
  } state_e;

  state_e state_q;
  logic lbb_q;
  logic [6:0] maxp_q;
  logic [19:0] maxb_q;
  logic [TagW-1:0] vt_q;
  in_item_t item_q;
  out_item_t res_q;
  flow_state_t fs_q;
  logic [FlowW:0] idx_q;
  logic [FlowW-1:0] sel_q;
  logic found_q, any_q;
  logic [TagW-1:0] best_q, mins_q, seed_q;
  logic [WsumW-1:0] wsum_q;
  entry_t ent_q;

  logic fs_we;
  logic [FlowW-1:0] fs_waddr, fs_raddr;
  flow_state_t fs_wdata, fs_rdata;
  logic st_we;
  logic [StoreAw-1:0] st_waddr, st_raddr;
  entry_t st_wdata, st_rdata;
  div_req_t dreq;
  div_rsp_t drsp;
  logic [PtrW-1:0] head_nxt, tail_nxt;

  wf2q_ram #(.Width(StateW), .Depth(NumFlows)) u_fs_ram (
    .clk_i, .we_i(fs_we), .waddr_i(fs_waddr), .wdata_i(fs_wdata),
    .raddr_i(fs_raddr), .rdata_o(fs_rdata)
  );
  wf2q_ram #(.Width(EntryW), .Depth(StoreDepth)) u_store_ram (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );
  wf2q_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic in_acc, last_idx, backlog, full;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (state_q == S_OUT);
  assign out_item_o = res_q;
  assign last_idx = (idx_q == (FlowW+1)'(NumFlows - 1));
  assign backlog = (fs_rdata.pkt_cnt != '0);
  assign full = (fs_q.pkt_cnt >= CntW'(QueueDepth)) ||
                (lbb_q ? (fs_q.byte_cnt >= maxb_q) : ({1'b0, fs_q.pkt_cnt} >= maxp_q));
  assign head_nxt = (fs_q.head == PtrW'(QueueDepth - 1)) ? '0 : fs_q.head + 1'b1;
  assign tail_nxt = (fs_q.tail == PtrW'(QueueDepth - 1)) ? '0 : fs_q.tail + 1'b1;

  always_comb begin
    fs_raddr = idx_q[FlowW-1:0];
    st_raddr = {sel_q, fs_q.head};
    fs_we = 1'b0;
    fs_waddr = sel_q;
    fs_wdata = fs_q;
    st_we = 1'b0;
    st_waddr = {sel_q, fs_q.tail};
    st_wdata = '{len: item_q.pkt_length, weight: item_q.pkt_weight,
                 handle: item_q.pkt_handle};
    dreq = '0;
    unique case (state_q)
      S_CLEAR: begin
        fs_we = 1'b1;
        fs_waddr = idx_q[FlowW-1:0];
        fs_wdata = '0;
      end
      S_IDLE: fs_raddr = in_item_i.flow_id[FlowW-1:0];
      S_EDIV1: dreq = '{start: 1'b1, len: item_q.pkt_length,
                        divisor: WsumW'(item_q.pkt_weight)};
      S_EPUSH: begin
        st_we = 1'b1;
        fs_we = 1'b1;
        fs_wdata.tail = tail_nxt;
        fs_wdata.pkt_cnt = fs_q.pkt_cnt + 1'b1;
        fs_wdata.byte_cnt = fs_q.byte_cnt + 20'(item_q.pkt_length);
      end
      S_DPICK: fs_raddr = sel_q;
      S_DNEXT: st_raddr = {sel_q, fs_q.head};
      S_DNEXTW: st_raddr = {sel_q, head_nxt};
      S_DDIV: dreq = '{start: 1'b1, len: st_rdata.len, divisor: WsumW'(ent_q.weight)};
      S_DWB: fs_we = 1'b1;
      S_VDIV: dreq = '{start: 1'b1, len: ent_q.len, divisor: wsum_q};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q <= '0;
      lbb_q <= 1'b0;
      maxp_q <= 7'd64;
      maxb_q <= 20'd150000;
      vt_q <= '0;
      sel_q <= '0;
      found_q <= 1'b0;
      any_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgLimitByBytes: lbb_q <= cfg_data_i[0];
          CfgMaxPackets: maxp_q <= cfg_data_i[6:0];
          CfgMaxBytes: maxb_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_CLEAR: begin
          idx_q <= idx_q + 1'b1;
          if (last_idx) state_q <= S_IDLE;
        end
        S_IDLE: if (in_acc) begin
          item_q <= in_item_i;
          sel_q <= in_item_i.flow_id[FlowW-1:0];
          res_q <= '0;
          idx_q <= '0;
          found_q <= 1'b0;
          any_q <= 1'b0;
          wsum_q <= '0;
          if (in_item_i.func) state_q <= S_SCAN;
          else if (32'(in_item_i.flow_id) >= NumFlows) begin
            res_q.status <= StDrop;
            state_q <= S_OUT;
          end else state_q <= S_ERD;
        end
        S_ERD: begin
          fs_q <= fs_rdata;
          state_q <= S_EDEC;
        end
        S_EDEC: begin
          if (full) begin
            res_q.status <= StDrop;
            state_q <= S_OUT;
          end else if (fs_q.pkt_cnt == '0) begin
            seed_q <= max_tag(vt_q, fs_q.finish_tag);
            state_q <= S_EDIV1;
          end else if (fs_q.seen && item_q.pkt_weight != fs_q.weight) begin
            seed_q <= vt_q;
            state_q <= S_EDIV1;
          end else state_q <= S_EPUSH;
        end
        S_EDIV1: state_q <= S_EWAIT1;
        S_EWAIT1: if (drsp.done) begin
          fs_q.weight <= item_q.pkt_weight;
          fs_q.seen <= 1'b1;
          fs_q.start_tag <= seed_q;
          fs_q.finish_tag <= sat_add(seed_q, drsp.quo);
          mins_q <= seed_q;
          idx_q <= '0;
          state_q <= S_EWAIT2;
        end
        S_EWAIT2: begin
          // Scan other flows for the least backlogged start; own flow uses fs_q.
          if (idx_q != '0 && idx_q[FlowW-1:0] - 1'b1 != sel_q && fs_rdata.pkt_cnt != '0 &&
              fs_rdata.start_tag < mins_q) mins_q <= fs_rdata.start_tag;
          if (idx_q == (FlowW+1)'(NumFlows)) state_q <= S_ECHK2;
          else idx_q <= idx_q + 1'b1;
        end
        S_ECHK2: begin
          if (mins_q > vt_q) vt_q <= mins_q;
          if (fs_q.pkt_cnt != '0 && fs_q.start_tag < mins_q && fs_q.start_tag > vt_q)
            vt_q <= fs_q.start_tag;
          if (fs_q.seen && item_q.pkt_weight != fs_q.weight) begin
            seed_q <= (mins_q > vt_q) ? mins_q : vt_q;
            state_q <= S_EDIV1;
          end else state_q <= S_EPUSH;
        end
        S_EPUSH: begin
          res_q.status <= StEnq;
          state_q <= S_OUT;
        end
        S_SCAN: begin
          idx_q <= idx_q + 1'b1;
          state_q <= S_SCANL;
        end
        S_SCANL: begin
          if (backlog && fs_rdata.start_tag <= vt_q &&
              (!found_q || fs_rdata.finish_tag < best_q)) begin
            found_q <= 1'b1;
            sel_q <= idx_q[FlowW-1:0] - 1'b1;
            best_q <= fs_rdata.finish_tag;
          end
          if (idx_q == (FlowW+1)'(NumFlows)) state_q <= S_DPICK;
          else idx_q <= idx_q + 1'b1;
        end
        S_DPICK: begin
          if (!found_q) begin
            res_q.status <= StNone;
            state_q <= S_OUT;
          end else begin
            idx_q <= {1'b0, sel_q};
            state_q <= S_DHEAD;
          end
        end
        S_DHEAD: begin
          fs_q <= fs_rdata;
          state_q <= S_DNEXT;
        end
        S_DNEXT: state_q <= S_DNEXTW;
        S_DNEXTW: begin
          ent_q <= st_rdata;
          fs_q.head <= head_nxt;
          fs_q.pkt_cnt <= fs_q.pkt_cnt - 1'b1;
          fs_q.byte_cnt <= (fs_q.byte_cnt >= 20'(st_rdata.len)) ?
                           fs_q.byte_cnt - 20'(st_rdata.len) : '0;
          state_q <= (fs_q.pkt_cnt > CntW'(1)) ? S_DDIV : S_DWB;
        end
        S_DDIV: state_q <= S_DWAIT;
        S_DWAIT: if (drsp.done) begin
          fs_q.start_tag <= fs_q.finish_tag;
          fs_q.finish_tag <= sat_add(fs_q.finish_tag, drsp.quo);
          state_q <= S_DWB;
        end
        S_DWB: begin
          idx_q <= '0;
          mins_q <= fs_q.start_tag;
          state_q <= S_MSCAN;
        end
        S_MSCAN: begin
          idx_q <= idx_q + 1'b1;
          state_q <= S_MSCANL;
        end
        S_MSCANL: begin
          wsum_q <= wsum_q + WsumW'(fs_rdata.weight);
          if (backlog && (!any_q || fs_rdata.start_tag < mins_q)) begin
            any_q <= 1'b1;
            mins_q <= fs_rdata.start_tag;
          end
          if (idx_q == (FlowW+1)'(NumFlows)) state_q <= S_VDIV;
          else idx_q <= idx_q + 1'b1;
        end
        S_VDIV: state_q <= S_VWAIT;
        S_VWAIT: if (drsp.done) begin
          vt_q <= max_tag(mins_q, sat_add(vt_q, drsp.quo));
          res_q <= '{status: StDeq, out_flow: 4'(sel_q), out_handle: ent_q.handle,
                     out_length: ent_q.len};
          state_q <= S_OUT;
        end
        S_OUT: if (!out_stall_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_stall_busy, clk_i, rst_ni, state_q != S_IDLE, in_stall_o,
               "input taken while busy")
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
               ##1 out_valid_o && $stable(out_item_o), "result lost while stalled")
  `ASSERT_NEVER(a_no_both, clk_i, rst_ni, out_valid_o && !in_stall_o,
                "accepting while a result waits")
endmodule
